[hdl/lsws_pkg.sv]
// Shared constants, codes and types of the load sum weight stability block.
`default_nettype none

package lsws_pkg;

  // Window and cell configuration
  localparam int WindowDepth = 16;
  localparam int CellCount   = 5;

  // Field widths
  localparam int ForceW  = 15;
  localparam int GainW   = 16;
  localparam int GainFrac = 12;
  localparam int WeightW = 20;
  localparam int LimitW  = 32;
  localparam int CfgIdxW = 8;
  localparam int CfgDataW = 32;

  // Derived widths
  localparam int PtrW      = $clog2(WindowDepth);
  localparam int ForceSumW = ForceW + $clog2(CellCount + 1);
  localparam int ProdGainW = ForceSumW + GainW;
  localparam int ScaledW   = ProdGainW + 1 - GainFrac;
  localparam int SumW      = WeightW + PtrW;
  localparam int SqSumW    = 2 * WeightW + PtrW;
  localparam int MulW      = SumW;
  localparam int ProdW     = 2 * MulW;
  localparam int CmpW      = 2 * SumW + 1;

  // Reset values of the registers
  localparam logic [GainW-1:0]   GainReset  = GainW'(4096);
  localparam logic [WeightW-1:0] TareReset  = WeightW'(0);
  localparam logic [WeightW-1:0] MaxReset   = WeightW'(128000);
  localparam logic [LimitW-1:0]  LimitReset = LimitW'(32768);

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CAL_GAIN       = 8'd0,
    CFG_TARE_OFFSET    = 8'd1,
    CFG_MAX_WEIGHT     = 8'd2,
    CFG_VARIANCE_LIMIT = 8'd3
  } cfg_idx_e;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_GAIN  = 7'b0000010,
    ST_CLAMP = 7'b0000100,
    ST_SQO   = 7'b0001000,
    ST_SQW   = 7'b0010000,
    ST_SQS   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

endpackage

`default_nettype wire

[hdl/lsws_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lsws_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

[hdl/load_sum_weight_stability.sv]
// Top level: load cell summer with sliding-window stability flag.
`default_nettype none

// Each accepted item of five forces is summed, scaled by the Q4.12 gain with
// round half up, tared and clamped to 0..max_weight, and the weight replaces
// the oldest of the last sixteen weights, held in a small RAM. Running sum and
// sum of squares over that window give the stable flag, set when
// 16*sumsq - sum^2 < limit*256. The item passes through the states GAIN,
// CLAMP, SQO, SQW, SQS and DONE, and the result is loaded into the output
// register from DONE. A single shared multiplier serves the gain product, the
// two squares for the running sum of squares and the square of the sum, one
// at a time. The next item is taken on the cycle after the result is loaded,
// not before; a stalled result holds the block in its last state. The window
// reads as zero after reset through a valid bit per entry, so no clearing pass
// is needed. Registers may be written at any time the block is idle; the
// configuration port is always ready.
module load_sum_weight_stability (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [lsws_pkg::ForceW-1:0]     force_a_i,
  input  wire logic [lsws_pkg::ForceW-1:0]     force_b_i,
  input  wire logic [lsws_pkg::ForceW-1:0]     force_c_i,
  input  wire logic [lsws_pkg::ForceW-1:0]     force_d_i,
  input  wire logic [lsws_pkg::ForceW-1:0]     force_e_i,
  // Output channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [lsws_pkg::WeightW-1:0]    total_weight_o,
  output logic                                 is_stable_o,
  // Configuration write channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [lsws_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [lsws_pkg::CfgDataW-1:0]   cfg_data_i
);

  lsws_pkg::state_e state_q, state_d;

  logic [lsws_pkg::GainW-1:0]     gain_q;
  logic [lsws_pkg::WeightW-1:0]   tare_q;
  logic [lsws_pkg::WeightW-1:0]   max_q;
  logic [lsws_pkg::LimitW-1:0]    limit_q;

  logic [lsws_pkg::ForceSumW-1:0] fsum_q;
  logic [lsws_pkg::ProdW-1:0]     prod_q;
  logic [lsws_pkg::WeightW-1:0]   old_q;
  logic [lsws_pkg::WeightW-1:0]   w_q;
  logic [lsws_pkg::SumW-1:0]      sum_q;
  logic [lsws_pkg::SqSumW-1:0]    sqsum_q;
  logic [lsws_pkg::PtrW-1:0]      ptr_q;
  logic [lsws_pkg::WindowDepth-1:0] valid_q;

  logic                           in_accept;
  logic                           out_free;
  logic [lsws_pkg::WeightW-1:0]   rd_data;
  logic                           ring_wr;

  logic [lsws_pkg::MulW-1:0]      mul_a, mul_b;
  logic [lsws_pkg::ScaledW-1:0]   scaled;
  logic [lsws_pkg::ScaledW-1:0]   tared;
  logic [lsws_pkg::WeightW-1:0]   w_new;
  logic [lsws_pkg::CmpW-1:0]      lhs, rhs;

  assign in_stall_o  = (state_q != lsws_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_o || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign ring_wr     = (state_q == lsws_pkg::ST_CLAMP);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= lsws_pkg::GainReset;
      tare_q  <= lsws_pkg::TareReset;
      max_q   <= lsws_pkg::MaxReset;
      limit_q <= lsws_pkg::LimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        lsws_pkg::CFG_CAL_GAIN:       gain_q  <= cfg_data_i[lsws_pkg::GainW-1:0];
        lsws_pkg::CFG_TARE_OFFSET:    tare_q  <= cfg_data_i[lsws_pkg::WeightW-1:0];
        lsws_pkg::CFG_MAX_WEIGHT:     max_q   <= cfg_data_i[lsws_pkg::WeightW-1:0];
        lsws_pkg::CFG_VARIANCE_LIMIT: limit_q <= cfg_data_i[lsws_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Weight ring storage
  lsws_ram #(
    .Width(lsws_pkg::WeightW),
    .Depth(lsws_pkg::WindowDepth)
  ) u_ring (
    .clk_i    (clk_i),
    .wr_en_i  (ring_wr),
    .wr_addr_i(ptr_q),
    .wr_data_i(w_new),
    .rd_en_i  (in_accept),
    .rd_addr_i(ptr_q),
    .rd_data_o(rd_data)
  );

  // Select the operands of the shared multiplier
  always_comb begin
    mul_a = lsws_pkg::MulW'(fsum_q);
    mul_b = lsws_pkg::MulW'(gain_q);
    case (state_q)
      lsws_pkg::ST_SQO: begin
        mul_a = lsws_pkg::MulW'(old_q);
        mul_b = lsws_pkg::MulW'(old_q);
      end
      lsws_pkg::ST_SQW: begin
        mul_a = lsws_pkg::MulW'(w_q);
        mul_b = lsws_pkg::MulW'(w_q);
      end
      lsws_pkg::ST_SQS: begin
        mul_a = sum_q;
        mul_b = sum_q;
      end
      default: ;
    endcase
  end

  // Round, tare and clamp the scaled sum
  always_comb begin
    scaled = lsws_pkg::ScaledW'(
      ({1'b0, prod_q[lsws_pkg::ProdGainW-1:0]} +
       (lsws_pkg::ProdGainW + 1)'(1 << (lsws_pkg::GainFrac - 1))) >> lsws_pkg::GainFrac);
    if (scaled <= lsws_pkg::ScaledW'(tare_q)) begin
      tared = '0;
    end else begin
      tared = scaled - lsws_pkg::ScaledW'(tare_q);
    end
    if (tared > lsws_pkg::ScaledW'(max_q)) begin
      w_new = max_q;
    end else begin
      w_new = tared[lsws_pkg::WeightW-1:0];
    end
  end

  // Variance test on the updated window
  assign lhs = lsws_pkg::CmpW'(sqsum_q) * lsws_pkg::CmpW'(lsws_pkg::WindowDepth);
  assign rhs = lsws_pkg::CmpW'(prod_q) +
               lsws_pkg::CmpW'(limit_q) *
               lsws_pkg::CmpW'(lsws_pkg::WindowDepth * lsws_pkg::WindowDepth);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lsws_pkg::ST_IDLE:  if (in_accept) state_d = lsws_pkg::ST_GAIN;
      lsws_pkg::ST_GAIN:  state_d = lsws_pkg::ST_CLAMP;
      lsws_pkg::ST_CLAMP: state_d = lsws_pkg::ST_SQO;
      lsws_pkg::ST_SQO:   state_d = lsws_pkg::ST_SQW;
      lsws_pkg::ST_SQW:   state_d = lsws_pkg::ST_SQS;
      lsws_pkg::ST_SQS:   state_d = lsws_pkg::ST_DONE;
      lsws_pkg::ST_DONE:  if (out_free) state_d = lsws_pkg::ST_IDLE;
      default:            state_d = lsws_pkg::ST_IDLE;
    endcase
  end

  // Control state: sequencer, ring pointer, valid bits, running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsws_pkg::ST_IDLE;
      ptr_q   <= '0;
      valid_q <= '0;
      sum_q   <= '0;
      sqsum_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == lsws_pkg::ST_CLAMP) begin
        valid_q[ptr_q] <= 1'b1;
        ptr_q <= (ptr_q == lsws_pkg::PtrW'(lsws_pkg::WindowDepth - 1)) ? '0 : ptr_q + 1'b1;
        sum_q <= sum_q - lsws_pkg::SumW'(old_q) + lsws_pkg::SumW'(w_new);
      end
      // Drop the old square, then add the new one
      if (state_q == lsws_pkg::ST_SQW) begin
        sqsum_q <= sqsum_q - prod_q[lsws_pkg::SqSumW-1:0];
      end
      if (state_q == lsws_pkg::ST_SQS) begin
        sqsum_q <= sqsum_q + prod_q[lsws_pkg::SqSumW-1:0];
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fsum_q <= lsws_pkg::ForceSumW'(force_a_i) + lsws_pkg::ForceSumW'(force_b_i) +
                lsws_pkg::ForceSumW'(force_c_i) + lsws_pkg::ForceSumW'(force_d_i) +
                lsws_pkg::ForceSumW'(force_e_i);
    end
    if (state_q == lsws_pkg::ST_GAIN) begin
      old_q <= valid_q[ptr_q] ? rd_data : '0;
    end
    if (state_q == lsws_pkg::ST_CLAMP) begin
      w_q <= w_new;
    end
    if (state_q != lsws_pkg::ST_IDLE && state_q != lsws_pkg::ST_CLAMP &&
        state_q != lsws_pkg::ST_DONE) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // Output register: hold while stalled, load at the end of an item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == lsws_pkg::ST_DONE && out_free) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lsws_pkg::ST_DONE && out_free) begin
      total_weight_o <= w_q;
      is_stable_o    <= (lhs < rhs);
    end
  end

endmodule

`default_nettype wire

[hdl/lsws_checker.sv]
// Port-level assertions for the load sum weight stability block, with bind.
`default_nettype none

module lsws_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [lsws_pkg::WeightW-1:0] total_weight_o,
  input wire logic                         is_stable_o
);

  // An accepted item keeps the input side busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an item was taken");

  // A new result only appears at the end of work on an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in progress");

  // A stalled result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(total_weight_o) && $stable(is_stable_o)))
    else $error("stalled result changed");

endmodule

bind load_sum_weight_stability lsws_checker u_lsws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .total_weight_o(total_weight_o),
  .is_stable_o   (is_stable_o)
);

`default_nettype wire

[verif/lsws_weight_checker.sv]
// Checker for the weight stability block: predicts each result and compares it.
`timescale 1ns / 1ps

module lsws_weight_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input channel
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [lsws_pkg::ForceW-1:0]     force_a_i,
  input  logic [lsws_pkg::ForceW-1:0]     force_b_i,
  input  logic [lsws_pkg::ForceW-1:0]     force_c_i,
  input  logic [lsws_pkg::ForceW-1:0]     force_d_i,
  input  logic [lsws_pkg::ForceW-1:0]     force_e_i,
  // Output channel
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [lsws_pkg::WeightW-1:0]    total_weight_i,
  input  logic                            is_stable_i,
  // Configuration write channel
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [lsws_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lsws_pkg::CfgDataW-1:0]   cfg_data_i,
  // Status towards the testbench top
  output int                              pending_o,
  output int                              fail_count_o,
  output int                              stable_count_o
);
  import lsws_pkg::*;

  typedef logic [CellCount-1:0][ForceW-1:0] cell_set_t;

  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic               stable;
  } weight_result_t;

  // Shadow copy of the registers
  logic [GainW-1:0]   gain_r;
  logic [WeightW-1:0] tare_r;
  logic [WeightW-1:0] max_r;
  logic [LimitW-1:0]  limit_r;

  // Shadow copy of the weight window
  logic [WeightW-1:0] window_ring [WindowDepth];
  int unsigned        next_slot;
  logic [63:0]        window_sum;
  logic [63:0]        window_sq_sum;

  weight_result_t     expected_q [$];
  int                 items_taken  = 0;
  int                 results_seen = 0;
  int                 fail_count   = 0;
  int                 stable_count = 0;

  assign pending_o      = items_taken - results_seen;
  assign fail_count_o   = fail_count;
  assign stable_count_o = stable_count;

  // Weigh one item, slide it into the window and judge the window spread
  function automatic weight_result_t weigh_item(input cell_set_t cells);
    logic [63:0]    force_sum;
    logic [63:0]    scaled;
    logic [63:0]    net;
    logic [63:0]    oldest;
    weight_result_t res;
    int             k;
    force_sum = '0;
    for (k = 0; k < CellCount; k++) force_sum += 64'(cells[k]);
    // Q4.12 gain, round half up
    scaled = (force_sum * 64'(gain_r) + (64'd1 << (GainFrac - 1))) >> GainFrac;
    // Tare floors at zero, then clamp to the upper limit
    net = (scaled <= 64'(tare_r)) ? 64'd0 : scaled - 64'(tare_r);
    if (net > 64'(max_r)) net = 64'(max_r);
    res.weight = net[WeightW-1:0];
    // Replace the oldest entry and keep the running sums in step
    oldest = 64'(window_ring[next_slot]);
    window_ring[next_slot] = res.weight;
    next_slot = (next_slot + 1) % WindowDepth;
    window_sum = window_sum - oldest + 64'(res.weight);
    window_sq_sum = window_sq_sum - oldest * oldest + 64'(res.weight) * 64'(res.weight);
    // N*sumsq - sum^2 < limit*N^2, rearranged to stay unsigned
    res.stable = (64'(WindowDepth) * window_sq_sum) <
                 (window_sum * window_sum + 64'(limit_r) * 64'(WindowDepth * WindowDepth));
    return res;
  endfunction

  // Track registers, predict on each item taken, compare each result taken
  always @(posedge clk_i or negedge rst_ni) begin : track
    weight_result_t want;
    int             k;
    if (!rst_ni) begin
      gain_r  = GainReset;
      tare_r  = TareReset;
      max_r   = MaxReset;
      limit_r = LimitReset;
      for (k = 0; k < WindowDepth; k++) window_ring[k] = '0;
      next_slot     = 0;
      window_sum    = '0;
      window_sq_sum = '0;
      expected_q.delete();
      items_taken  <= 0;
      results_seen <= 0;
    end else begin
      // Register writes; indexes past the list are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CAL_GAIN:       gain_r  = cfg_data_i[GainW-1:0];
          CFG_TARE_OFFSET:    tare_r  = cfg_data_i[WeightW-1:0];
          CFG_MAX_WEIGHT:     max_r   = cfg_data_i[WeightW-1:0];
          CFG_VARIANCE_LIMIT: limit_r = cfg_data_i[LimitW-1:0];
          default: ;
        endcase
      end

      // Compare the result against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing outstanding, expected none, got weight %0d stable %0b",
                   $time, total_weight_i, is_stable_i);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (want.stable) stable_count++;
          if (total_weight_i !== want.weight) begin
            $display("%0t: total_weight expected %0d, got %0d",
                     $time, want.weight, total_weight_i);
            fail_count++;
          end
          if (is_stable_i !== want.stable) begin
            $display("%0t: is_stable expected %0b, got %0b", $time, want.stable, is_stable_i);
            fail_count++;
          end
        end
      end

      // Predict the item taken at this edge
      if (in_valid_i && !in_stall_i) begin
        items_taken <= items_taken + 1;
        expected_q.push_back(weigh_item({force_e_i, force_d_i, force_c_i, force_b_i, force_a_i}));
      end
    end
  end

endmodule

[verif/tb_load_sum_weight_stability.sv]
// Testbench top for the weight stability block: stimulus, register phases and verdict.
`timescale 1ns / 1ps

module tb_load_sum_weight_stability;
  import lsws_pkg::*;

  localparam int IdleLimit   = 4000;
  localparam int TargetItems = 950;
  localparam int SettleCycles = 16;
  localparam int NominalMax  = 25600;

  localparam logic [ForceW-1:0] ForceAll = '1;
  localparam logic [GainW-1:0]  GainHalf = GainW'(2048);

  typedef logic [CellCount-1:0][ForceW-1:0] cell_set_t;

  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY} flow_e;
  typedef enum int {SEQ_STEADY, SEQ_DRIFT, SEQ_NOISE, SEQ_EDGE} seq_e;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [ForceW-1:0]   force_a   = '0;
  logic [ForceW-1:0]   force_b   = '0;
  logic [ForceW-1:0]   force_c   = '0;
  logic [ForceW-1:0]   force_d   = '0;
  logic [ForceW-1:0]   force_e   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [WeightW-1:0]  total_weight;
  logic                is_stable;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  int    pending;
  int    fail_count;
  int    stable_count;
  int    items_sent    = 0;
  int    settings_used = 0;
  int    idle_cycles   = 0;
  flow_e flow_mode     = FLOW_FREE;
  int    flow_left     = 0;

  load_sum_weight_stability i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .force_a_i      (force_a),
    .force_b_i      (force_b),
    .force_c_i      (force_c),
    .force_d_i      (force_d),
    .force_e_i      (force_e),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .total_weight_o (total_weight),
    .is_stable_o    (is_stable),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  lsws_weight_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .force_a_i      (force_a),
    .force_b_i      (force_b),
    .force_c_i      (force_c),
    .force_d_i      (force_d),
    .force_e_i      (force_e),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .total_weight_i (total_weight),
    .is_stable_i    (is_stable),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .pending_o      (pending),
    .fail_count_o   (fail_count),
    .stable_count_o (stable_count)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort when no handshake of any kind completes for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, IdleLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver back-pressure: free, light and heavy stretches of random length
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      flow_mode <= FLOW_FREE;
      flow_left <= 0;
    end else begin
      if (flow_left == 0) begin
        flow_mode <= flow_e'($urandom_range(FLOW_FREE, FLOW_HEAVY));
        flow_left <= $urandom_range(16, 160);
      end else begin
        flow_left <= flow_left - 1;
      end
      case (flow_mode)
        FLOW_FREE:  out_stall <= 1'b0;
        FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        default:    out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Offer one item and hold it until it is taken
  task automatic send_item(input cell_set_t cells);
    in_valid <= 1'b1;
    force_a  <= cells[0];
    force_b  <= cells[1];
    force_c  <= cells[2];
    force_d  <= cells[3];
    force_e  <= cells[4];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid for a gap of idle cycles
  task automatic hold_sender(input int gap);
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Offer one register write and hold it until it is taken
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write a stray index first, then all four registers, the first three with junk above their widths
  task automatic load_settings(input logic [GainW-1:0] gain, input logic [WeightW-1:0] tare,
                               input logic [WeightW-1:0] max_w, input logic [LimitW-1:0] limit);
    write_reg(CfgIdxW'($urandom_range(CFG_VARIANCE_LIMIT + 1, 2**CfgIdxW - 1)), $urandom);
    write_reg(CFG_CAL_GAIN, CfgDataW'({$urandom, gain}));
    write_reg(CFG_TARE_OFFSET, CfgDataW'({$urandom, tare}));
    write_reg(CFG_MAX_WEIGHT, CfgDataW'({$urandom, max_w}));
    write_reg(CFG_VARIANCE_LIMIT, limit);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    cell_set_t          cells;
    int                 base [CellCount];
    int                 amp;
    int                 drift_step;
    int                 phase_len;
    int                 burst_left;
    int                 r;
    int                 k;
    int                 n;
    bit                 gappy;
    seq_e               seq;
    logic [GainW-1:0]   gain;
    logic [WeightW-1:0] tare;
    logic [WeightW-1:0] max_w;
    logic [LimitW-1:0]  limit;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zero, nominal full scale, beyond-range forces, bit patterns
    send_item({CellCount{15'd0}});
    send_item({CellCount{ForceW'(NominalMax)}});
    send_item({CellCount{ForceAll}});
    send_item({{(CellCount-1){15'd0}}, ForceAll});
    send_item({CellCount{15'h5555}});
    send_item({CellCount{15'h2AAA}});

    // Largest gain, no clamp below the top of the range, widest limit
    drain_results();
    load_settings('1, '0, '1, '1);
    send_item({CellCount{ForceAll}});
    send_item({{(CellCount-1){15'd0}}, 15'd1});
    send_item({CellCount{15'd0}});

    // Tare above any scaled sum: weight floors at zero; zero limit never stable
    drain_results();
    load_settings(GainHalf, '1, MaxReset, '0);
    send_item({CellCount{ForceAll}});
    send_item({{(CellCount-1){15'd0}}, 15'd1});

    // Half gain rounding up on odd sums, zero upper clamp
    drain_results();
    load_settings(GainHalf, 1, '0, 1);
    send_item({{(CellCount-1){15'd0}}, 15'd1});
    send_item({{(CellCount-1){15'd0}}, 15'd3});

    // Zero gain: every weight reads zero
    drain_results();
    load_settings('0, '0, '1, 1);
    repeat (3) send_item({CellCount{ForceAll}});

    // Random phases, each under fresh settings after a full drain
    while (items_sent < TargetItems) begin
      drain_results();

      case ($urandom_range(0, 5))
        0:       gain = '0;
        1:       gain = '1;
        2, 3:    gain = GainW'($urandom_range(3500, 4700));
        default: gain = GainW'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0, 1:    tare = '0;
        2, 3:    tare = WeightW'($urandom_range(0, 20000));
        4:       tare = WeightW'($urandom);
        default: tare = '1;
      endcase
      case ($urandom_range(0, 5))
        0:       max_w = '1;
        1:       max_w = MaxReset;
        2:       max_w = WeightW'($urandom);
        3:       max_w = WeightW'($urandom_range(0, 1000));
        4:       max_w = '0;
        default: max_w = WeightW'($urandom_range(100000, 200000));
      endcase
      case ($urandom_range(0, 5))
        0:       limit = '0;
        1:       limit = '1;
        2:       limit = LimitW'($urandom_range(0, 4096));
        3:       limit = LimitW'($urandom_range(0, 65536));
        4:       limit = LimitReset;
        default: limit = LimitW'($urandom);
      endcase
      load_settings(gain, tare, max_w, limit);

      // Mostly steady loads with small jitter so the window can settle
      r = $urandom_range(0, 9);
      seq = (r < 5) ? SEQ_STEADY : (r < 7) ? SEQ_DRIFT : (r < 9) ? SEQ_NOISE : SEQ_EDGE;
      for (k = 0; k < CellCount; k++) base[k] = $urandom_range(0, NominalMax);
      amp        = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 8) : $urandom_range(0, 400);
      drift_step = $urandom_range(0, 40);
      phase_len  = $urandom_range(30, 90);
      gappy      = ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(1, 16);

      for (n = 0; n < phase_len; n++) begin
        for (k = 0; k < CellCount; k++) begin
          case (seq)
            SEQ_STEADY: cells[k] = ForceW'(base[k] + $urandom_range(0, amp));
            SEQ_DRIFT: begin
              base[k] = (base[k] + drift_step) % (NominalMax + 1);
              cells[k] = ForceW'(base[k]);
            end
            SEQ_NOISE: cells[k] = ForceW'($urandom);
            default: begin
              case ($urandom_range(0, 3))
                0:       cells[k] = '0;
                1:       cells[k] = ForceW'(NominalMax);
                2:       cells[k] = ForceAll;
                default: cells[k] = ForceW'($urandom);
              endcase
            end
          endcase
        end
        send_item(cells);

        // Bursts with random gaps, unless this phase streams back to back
        if (gappy) begin
          burst_left--;
          if (burst_left == 0) begin
            hold_sender($urandom_range(1, 12));
            burst_left = $urandom_range(1, 16);
          end
        end
      end
    end

    // Wait out the last results, then give stray outputs a chance to show
    drain_results();
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d items under %0d register settings besides reset; %0d stable windows seen.",
             items_sent, settings_used, stable_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/lsws_pkg.sv
hdl/lsws_ram.sv
hdl/load_sum_weight_stability.sv
hdl/lsws_checker.sv
verif/lsws_weight_checker.sv
verif/tb_load_sum_weight_stability.sv
